FILE: rtl/core/dbsr_pkg.sv
// Shared types and constants of the deadband sign run detector.
// Used by dbsr_core, dbsr_fifo and the top level; no dependencies.
package dbsr_pkg;

    localparam int unsigned DEPTH_DEFAULT = 1024;
    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned CUTOFF_W      = 15;
    localparam int unsigned MINRUN_W      = 11;
    localparam int unsigned RUNLEN_W      = 11;
    localparam int unsigned END_IDX_W     = 10;
    localparam int unsigned FIFO_DEPTH    = 4;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(410);
    localparam logic [MINRUN_W-1:0] MINRUN_RESET = MINRUN_W'(50);
    localparam logic [RUNLEN_W-1:0] RUN_MAX      = '1;

    // Configuration register indexes.
    localparam logic REG_CUTOFF = 1'b0;
    localparam logic REG_MINRUN = 1'b1;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_POS  = 2'd1,
        CLS_NEG  = 2'd2,
        CLS_ZERO = 2'd3
    } cls_t;

    typedef struct packed {
        logic                 sign;
        logic [END_IDX_W-1:0] idx;
        logic                 last;
    } res_t;

    // Results produced by one transaction, packed from r0 upward.
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

FILE: rtl/core/dbsr_core.sv
// Classification, run counting and run qualification for one sample per cycle while accept is high.
// Depends on dbsr_pkg.
module dbsr_core #(
    parameter int unsigned DEPTH = dbsr_pkg::DEPTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  accept,
    input  logic signed [dbsr_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  end_of_record,
    input  logic [dbsr_pkg::CUTOFF_W-1:0]         cutoff,
    input  logic [dbsr_pkg::MINRUN_W-1:0]         min_run,
    output dbsr_pkg::push_t                       push
);
    import dbsr_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    cls_t               cur_reg,   cur_next;
    cls_t               emit_reg,  emit_next;
    logic [RUNLEN_W-1:0] len_reg,  len_next;
    logic [IDX_W-1:0]   idx_reg,   idx_next;

    logic signed [SAMPLE_W:0] s_ext, cut_pos, cut_neg;
    cls_t cls_in;
    cls_t emit_mid;
    logic changed, flush, emit0, emit1;
    res_t res0, res1;

    always_comb begin
        s_ext   = {sample[SAMPLE_W-1], sample};
        cut_pos = $signed({2'b00, cutoff});
        cut_neg = -cut_pos;
        if (s_ext > cut_pos) begin
            cls_in = CLS_POS;
        end else if (s_ext < cut_neg) begin
            cls_in = CLS_NEG;
        end else begin
            cls_in = CLS_ZERO;
        end

        changed = (cls_in != cur_reg);
        flush   = end_of_record || (idx_reg == IDX_LAST);

        // Judge the run that ended with the previous sample.
        emit0 = changed && (len_reg != '0)
                && (cur_reg == CLS_POS || cur_reg == CLS_NEG)
                && (len_reg >= min_run) && (cur_reg != emit_reg);
        emit_mid = emit0 ? cur_reg : emit_reg;

        if (changed) begin
            cur_next = cls_in;
            len_next = RUNLEN_W'(1);
        end else begin
            cur_next = cur_reg;
            len_next = (len_reg < RUN_MAX) ? len_reg + RUNLEN_W'(1) : len_reg;
        end

        // Judge the run in progress when the recording closes.
        emit1 = flush && (cur_next == CLS_POS || cur_next == CLS_NEG)
                && (len_next >= min_run) && (cur_next != emit_mid);
        emit_next = emit1 ? cur_next : emit_mid;

        res0.sign = (cur_reg == CLS_NEG);
        res0.idx  = END_IDX_W'(idx_reg - IDX_W'(1));
        res0.last = !emit1;
        res1.sign = (cur_next == CLS_NEG);
        res1.idx  = END_IDX_W'(idx_reg);
        res1.last = 1'b1;

        push.n  = {1'b0, emit0} + {1'b0, emit1};
        push.r0 = emit0 ? res0 : res1;
        push.r1 = res1;
        if (!accept) begin
            push.n = 2'd0;
        end

        idx_next = idx_reg + IDX_W'(1);
        if (flush) begin
            cur_next  = CLS_NONE;
            len_next  = '0;
            idx_next  = '0;
            emit_next = CLS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= CLS_NONE;
            emit_reg <= CLS_NONE;
            len_reg  <= '0;
            idx_reg  <= '0;
        end else if (accept) begin
            cur_reg  <= cur_next;
            emit_reg <= emit_next;
            len_reg  <= len_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

FILE: rtl/core/dbsr_fifo.sv
// Small result queue that takes up to two results per cycle and gives one per pop.
// Depends on dbsr_pkg.
module dbsr_fifo (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  dbsr_pkg::push_t                            push,
    input  logic                                       pop,
    output dbsr_pkg::res_t                             head,
    output logic [$clog2(dbsr_pkg::FIFO_DEPTH):0]      level
);
    import dbsr_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned LVL_W = PTR_W + 1;

    res_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    always_comb begin
        wr_next  = wr_reg + PTR_W'(push.n);
        rd_next  = rd_reg + PTR_W'(pop);
        lvl_next = lvl_reg + LVL_W'(push.n) - LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    assign head  = mem_reg[rd_reg];
    assign level = lvl_reg;

endmodule

FILE: rtl/core/deadband_sign_run_detector.sv
// Top level of the deadband sign run detector.
// Depends on dbsr_pkg, dbsr_core and dbsr_fifo.
//
// Usage:
// The slave channel carries one signed Q5.11 rate sample per transaction in
// s_tdata; s_tlast marks the final sample of a recording. Each sample is
// classed as positive, negative or zero against the deadband cutoff, and a
// run of one sign that lasts at least min_run samples and differs from the
// sign reported before it produces a result when it ends.
// The master channel gives one result per transaction: the run's last sample
// index in m_tdata, its sign in m_tuser (1 for negative), and m_tlast on the
// last result caused by one input transaction. A single input can cause two
// results: the run that just ended and, at the end of a recording, the run
// in progress. After the final sample (s_tlast, or index DEPTH-1) all run
// state clears for the next recording; the configuration keeps its values.
// m_tvalid rises in the cycle after acceptance if the queue was empty. The core
// takes one sample per cycle; results leave through a four-entry queue, one per
// cycle, and s_tready is high while the queue has room for two results. So a
// stalled receiver stops the input once three or four results are pending, and
// the sustained rate is one sample per cycle while results do not outpace the
// one-per-cycle output port.
// Reset (aresetn low, synchronous) empties the queue, clears run state and
// restores the cutoff to 410 (0.2) and min_run to 50. The user must write the
// configuration through cfg_we, cfg_index and cfg_wdata only while idle (not enforced).
module deadband_sign_run_detector #(
    parameter int unsigned DEPTH = dbsr_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // [15:0] sample
    input  logic                                s_tlast,  // end_of_record
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,  // [9:0] end_index, zeros above
    output logic                                m_tuser,  // [0] run_sign
    output logic                                m_tlast,  // last_result
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [dbsr_pkg::CUTOFF_W-1:0]       cfg_wdata
);
    import dbsr_pkg::*;

    localparam int unsigned LVL_W = $clog2(FIFO_DEPTH) + 1;

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [MINRUN_W-1:0] minrun_reg;
    logic                accept;
    logic                pop;
    push_t               push;
    res_t                head;
    logic [LVL_W-1:0]    level;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
            minrun_reg <= MINRUN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CUTOFF: cutoff_reg <= cfg_wdata;
                REG_MINRUN: minrun_reg <= cfg_wdata[MINRUN_W-1:0];
                default:    cutoff_reg <= cutoff_reg;
            endcase
        end
    end

    // Room for the worst case of two results keeps the input open.
    assign s_tready = (level <= LVL_W'(FIFO_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    dbsr_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .sample        ($signed(s_tdata)),
        .end_of_record (s_tlast),
        .cutoff        (cutoff_reg),
        .min_run       (minrun_reg),
        .push          (push)
    );

    dbsr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .level   (level)
    );

    assign m_tvalid = (level != '0);
    assign m_tdata  = 16'(head.idx);
    assign m_tuser  = head.sign;
    assign m_tlast  = head.last;

    // The queue never overfills.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= LVL_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // Two results from one transaction always alternate in sign.
    a_two_alternate: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd2) |-> (push.r0.sign != push.r1.sign))
        else $error("repeated sign within one transaction");

    // A result pushed into an empty queue is offered in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (level == '0 && push.n != 2'd0) |=> m_tvalid)
        else $error("result not offered one cycle after acceptance");

endmodule

FILE: bench/deadband_sign_run_detector_test.sv
// Self-checking testbench for the deadband sign run detector.
// Depends on dbsr_pkg and the deadband_sign_run_detector top level; it keeps its own
// model of the run tracking and checks every result transaction against it.
module deadband_sign_run_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dbsr_pkg::*;

    localparam int unsigned DEPTH        = DEPTH_DEFAULT;
    localparam int unsigned RUN_CEILING  = RUN_MAX;
    localparam int          RANDOM_ITEMS = 150;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          SETTLE_TIME  = 8;

    // Receiver stall patterns.
    localparam int RX_FREE    = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_SLOW    = 2;
    localparam int RX_PATTERN = 3;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_we;
    logic                cfg_index;
    logic [CUTOFF_W-1:0] cfg_wdata;

    deadband_sign_run_detector #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Mirror of the configuration registers as the block should hold them.
    logic [CUTOFF_W-1:0] cutoff_q;
    logic [MINRUN_W-1:0] min_run_q;

    // Mirror of the run tracking state.
    cls_t        cls_now;
    int unsigned run_len;
    int unsigned smp_idx;
    cls_t        reported_cls;

    // Runs reported by the sample being tracked, and every run report that the
    // block still owes us, oldest first.
    res_t step_reports[$];
    res_t pending_runs[$];

    int error_count;
    int items_sent;
    int results_checked;
    int reg_writes;
    int cycle_count;
    int burst_remaining;

    // ------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The limit is far above the slowest legal run: every transaction waiting out
    // the longest sender gap plus two results behind the slowest stall pattern.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d run reports outstanding",
                     cycle_count, pending_runs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run tracking model.
    // ------------------------------------------------------------------
    function automatic void clear_tracking();
        cls_now      = CLS_NONE;
        run_len      = 0;
        smp_idx      = 0;
        reported_cls = CLS_NONE;
    endfunction

    // A finished run is reported only if it has a sign, is long enough and
    // differs in sign from the run reported before it.
    function automatic void judge_run(input cls_t c, input int unsigned len,
                                      input int unsigned idx);
        res_t r;
        if (c != CLS_POS && c != CLS_NEG)
            return;
        if (len < min_run_q)
            return;
        if (c == reported_cls)
            return;
        reported_cls = c;
        r.sign = (c == CLS_NEG);
        r.idx  = idx[END_IDX_W-1:0];
        r.last = 1'b0;
        step_reports = {step_reports, r};
    endfunction

    // Called once per accepted input transaction.
    function automatic void track_sample(input logic [15:0] raw, input logic eor);
        int   smp;
        int   cut;
        cls_t c;
        smp = $signed(raw);
        cut = int'(cutoff_q);
        if (smp > cut)
            c = CLS_POS;
        else if (smp < -cut)
            c = CLS_NEG;
        else
            c = CLS_ZERO;

        step_reports.delete();
        // The run that ended on the previous sample is judged first.
        if (c != cls_now) begin
            if (run_len > 0)
                judge_run(cls_now, run_len, smp_idx - 1);
            cls_now = c;
            run_len = 1;
        end else if (run_len < RUN_CEILING) begin
            run_len++;
        end

        // End of a recording: the run in progress is flushed and all state clears.
        if (eor || smp_idx >= DEPTH - 1) begin
            judge_run(cls_now, run_len, smp_idx);
            clear_tracking();
        end else begin
            smp_idx++;
        end

        if (step_reports.size() > 0)
            step_reports[step_reports.size() - 1].last = 1'b1;
        foreach (step_reports[i])
            pending_runs = {pending_runs, step_reports[i]};
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result transaction is compared with the
    // oldest outstanding run report.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_runs.size() == 0) begin
                $error("unexpected result: end_index=%0d run_sign=%0d last_result=%0d",
                       m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                want = pending_runs.pop_front();
                // The bits above the index must read as zero.
                if (m_tdata !== {{(16 - END_IDX_W){1'b0}}, want.idx}) begin
                    $error("end_index: expected %0d, got %0d", want.idx, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.sign) begin
                    $error("run_sign: expected %0d, got %0d", want.sign, m_tuser);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_result: expected %0d, got %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: m_tready follows one stall pattern for a while, then picks
    // another. Free-running stretches leave the output unthrottled.
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int remaining;
        int phase;
        m_tready  = 1'b0;
        mode      = RX_FREE;
        remaining = 0;
        phase     = 0;
        forever begin
            @(negedge aclk);
            if (remaining == 0) begin
                mode      = $urandom_range(RX_FREE, RX_PATTERN);
                remaining = $urandom_range(20, 200);
            end
            remaining--;
            phase++;
            case (mode)
                RX_FREE:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_SLOW:    m_tready <= ($urandom_range(0, 5) == 0);
                default:    m_tready <= (phase % 5 < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers.
    // ------------------------------------------------------------------
    // The sender works in bursts with idle gaps between them, except that
    // some bursts follow each other back to back.
    function automatic int next_gap();
        if (burst_remaining > 0) begin
            burst_remaining--;
            return 0;
        end
        burst_remaining = $urandom_range(1, 40);
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(1, 8);
    endfunction

    // Sends one sample as one input transaction and tracks it once accepted.
    task automatic send_sample(input logic [15:0] smp, input logic eor);
        int gap;
        gap = next_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= eor;
        do @(posedge aclk); while (!s_tready);
        track_sample(smp, eor);
        items_sent++;
    endtask

    // A run of identical samples; the end-of-record flag goes on the last one.
    task automatic send_run(input logic [15:0] smp, input int count, input logic eor_last);
        for (int k = 0; k < count; k++)
            send_sample(smp, eor_last && (k == count - 1));
    endtask

    task automatic hold_sender_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // Waits until every owed result has arrived, then lets the pipeline settle
    // in case the last transactions produced nothing.
    task automatic drain_results();
        hold_sender_idle();
        while (pending_runs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TIME) @(negedge aclk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(input logic idx, input logic [CUTOFF_W-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_CUTOFF)
            cutoff_q = val;
        else
            min_run_q = val[MINRUN_W-1:0];
        reg_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic cls_t pick_class();
        case ($urandom_range(0, 2))
            0:       return CLS_POS;
            1:       return CLS_NEG;
            default: return CLS_ZERO;
        endcase
    endfunction

    // A sample of the wanted class under the current cutoff, biased toward
    // the edges of the class. With the cutoff at full scale nothing is
    // positive, so a zero-class sample is given instead.
    function automatic logic [15:0] pick_sample(input cls_t c);
        int cut;
        int v;
        cut = int'(cutoff_q);
        if (c == CLS_POS && cut < 32767) begin
            case ($urandom_range(0, 3))
                0:       v = cut + 1;
                1:       v = 32767;
                default: v = int'($urandom_range(cut + 1, 32767));
            endcase
        end else if (c == CLS_NEG) begin
            case ($urandom_range(0, 3))
                0:       v = -cut - 1;
                1:       v = -32768;
                default: v = -int'($urandom_range(cut + 1, 32768));
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0:       v = cut;
                1:       v = -cut;
                2:       v = 0;
                default: v = int'($urandom_range(0, 2 * cut)) - cut;
            endcase
        end
        return v[15:0];
    endfunction

    // Run lengths cluster around the qualifying length so both outcomes occur; above 64 they run from 1 to 30.
    function automatic int pick_run_length();
        int m;
        m = int'(min_run_q);
        if (m > 64)
            return $urandom_range(1, 30);
        case ($urandom_range(0, 3))
            0:       return (m > 1) ? m - 1 : 1;
            1:       return (m > 0) ? m : 1;
            2:       return m + 1;
            default: return $urandom_range(1, 2 * m + 3);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Reset values: cutoff 410 and a qualifying length of 50.
    task automatic test_reset_defaults();
        send_run(16'sd410, 1, 1'b0);
        send_run(16'sd411, 50, 1'b0);
        send_run(-16'sd410, 1, 1'b1);
    endtask

    // Class boundaries, suppression of a repeated sign, two results from one
    // transaction, and both extremes of the cutoff.
    task automatic test_directed_cases();
        write_reg(REG_CUTOFF, 15'd100);
        write_reg(REG_MINRUN, 15'd2);
        send_run(16'sd101, 2, 1'b0);
        send_run(16'sd100, 1, 1'b0);       // positive run ends and is reported
        send_run(-16'sd100, 1, 1'b0);
        send_run(16'sd101, 3, 1'b0);       // zero run ends, never reported
        send_run(-16'sd101, 2, 1'b0);      // second positive run is suppressed
        send_run(-16'sd32768, 1, 1'b0);
        send_run(16'sd32767, 1, 1'b0);     // negative run ends and is reported
        send_run(16'sd0, 1, 1'b1);         // short positive run is dropped

        // With a qualifying length of one, a run change on the final sample
        // gives the ended run and the flushed run from the same transaction.
        write_reg(REG_MINRUN, 15'd1);
        send_run(-16'sd1000, 1, 1'b0);
        send_run(16'sd1000, 1, 1'b1);
        send_run(16'sd5, 1, 1'b1);
        send_run(-16'sd101, 1, 1'b1);

        // Zero cutoff: only an exact zero falls inside the deadband.
        write_reg(REG_CUTOFF, 15'd0);
        send_run(16'sd1, 1, 1'b0);
        send_run(16'sd0, 1, 1'b0);
        send_run(-16'sd1, 1, 1'b1);

        // Full-scale cutoff: only the most negative code leaves the deadband.
        write_reg(REG_CUTOFF, 15'd32767);
        send_run(16'sd32767, 1, 1'b0);
        send_run(-16'sd32767, 1, 1'b0);
        send_run(-16'sd32768, 1, 1'b1);
    endtask

    // New register values every other recording, the extremes included. The
    // min_run write sometimes carries junk in the unused upper bits.
    task automatic pick_random_setting();
        logic [CUTOFF_W-1:0] cut;
        logic [MINRUN_W-1:0] mr;
        case ($urandom_range(0, 5))
            0:       cut = 15'd0;
            1:       cut = 15'd32767;
            2:       cut = 15'(CUTOFF_RESET);
            3:       cut = 15'($urandom_range(0, 32767));
            default: cut = 15'($urandom_range(0, 2000));
        endcase
        case ($urandom_range(0, 15))
            0:       mr = 11'd0;
            1:       mr = 11'd1024;
            2:       mr = MINRUN_RESET;
            3:       mr = 11'd2047;
            default: mr = 11'($urandom_range(1, 8));
        endcase
        write_reg(REG_CUTOFF, cut);
        write_reg(REG_MINRUN, {4'($urandom_range(0, 15)), mr});
    endtask

    // Recordings built from runs of random class and length around the
    // qualifying length, with some raw noise mixed in. Most recordings end
    // with s_tlast; the others run on into the next one.
    task automatic test_random_recordings();
        int   rec;
        int   runs;
        int   len;
        int   random_items;
        cls_t c;
        logic [15:0] smp;
        logic eor;
        rec          = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (rec % 2 == 0)
                pick_random_setting();
            runs = $urandom_range(1, 10);
            for (int r = 0; r < runs && random_items < RANDOM_ITEMS; r++) begin
                c   = pick_class();
                len = pick_run_length();
                for (int k = 0; k < len; k++) begin
                    eor = (r == runs - 1) && (k == len - 1) && ($urandom_range(0, 7) != 0);
                    if ($urandom_range(0, 15) == 0)
                        smp = 16'($urandom);
                    else
                        smp = pick_sample(c);
                    send_sample(smp, eor);
                    random_items++;
                end
            end
            rec++;
        end
    endtask

    // A recording that reaches the last index, built from short runs of
    // random class. It is closed by the index alone or, on a coin toss, by
    // s_tlast landing on the last index too. A short recording afterward
    // confirms that the index and the reported sign start over.
    task automatic test_full_depth();
        int   k;
        int   len;
        cls_t c;
        logic eor_at_end;
        write_reg(REG_CUTOFF, 15'(CUTOFF_RESET));
        write_reg(REG_MINRUN, 15'd3);
        eor_at_end = 1'($urandom_range(0, 1));
        k = 0;
        while (k < DEPTH) begin
            c   = pick_class();
            len = $urandom_range(1, 10);
            for (int j = 0; j < len && k < DEPTH; j++) begin
                send_sample(pick_sample(c), eor_at_end && (k == DEPTH - 1));
                k++;
            end
        end
        send_run(-16'sd2000, 3, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_CUTOFF;
        cfg_wdata       = '0;
        cutoff_q        = CUTOFF_RESET;
        min_run_q       = MINRUN_RESET;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        reg_writes      = 0;
        cycle_count     = 0;
        burst_remaining = 0;
        clear_tracking();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_full_depth();
        test_random_recordings();

        drain_results();
        repeat (SETTLE_TIME) @(posedge aclk);

        $display("Sent %0d samples and checked %0d run reports over %0d register writes,",
                 items_sent, results_checked, reg_writes);
        $display("including boundary classes, repeated-sign suppression and a full-depth flush.");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: deadband_sign_run_detector.f
rtl/core/dbsr_pkg.sv
rtl/core/dbsr_core.sv
rtl/core/dbsr_fifo.sv
rtl/core/deadband_sign_run_detector.sv
bench/deadband_sign_run_detector_test.sv
